>>> rtl/core/cci_pkg.sv
// ============================================================================
// cci_pkg
// Shared widths, request/result types and pipeline payloads for the
// circle-circle intersection datapath.
// ============================================================================
package cci_pkg;

    // Field widths of a request and a result
    localparam int COORD_W    = 32;
    localparam int RAD_W      = 31;

    // Internal datapath widths
    localparam int DIFF_W     = COORD_W + 1;        // centre difference / sum
    localparam int RSQ_W      = 2 * RAD_W;          // radius squared
    localparam int E_W        = RSQ_W + 1;          // r1^2 - r2^2, signed
    localparam int SQ_W       = 64;                 // squared distance when circles meet
    localparam int RAD2_W     = 2 * SQ_W;           // root argument
    localparam int ROOT_W     = SQ_W;               // square root result
    localparam int SQRT_REM_W = ROOT_W + 2;         // partial remainder of the root
    localparam int MA_W       = SQ_W + 1;           // multiplier operand a, signed
    localparam int MB_W       = DIFF_W;             // multiplier operand b, signed
    localparam int ML_W       = 32;                 // low split of operand a
    localparam int MPP_W      = 2 * (MA_W - ML_W);  // partial product
    localparam int MP_W       = 98;                 // full product
    localparam int NUM_W      = 100;                // numerator, signed
    localparam int DEN_W      = SQ_W + 1;           // 2 * D2
    localparam int DIV_REM_W  = DEN_W + 1;          // partial remainder of the divide
    localparam int QUO_W      = COORD_W;            // quotient bits kept
    localparam int DIV_LAT    = QUO_W + 3;          // prep, range check, steps, saturate

    localparam logic [QUO_W-1:0] QUO_POS_MAX = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] QUO_NEG_MIN = {1'b1, {(QUO_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] first_center_x;
        logic signed [COORD_W-1:0] first_center_y;
        logic        [RAD_W-1:0]   first_radius;
        logic signed [COORD_W-1:0] second_center_x;
        logic signed [COORD_W-1:0] second_center_y;
        logic        [RAD_W-1:0]   second_radius;
    } circles_t;

    typedef struct packed {
        logic                      meet_valid;
        logic signed [COORD_W-1:0] point_a_x;
        logic signed [COORD_W-1:0] point_a_y;
        logic signed [COORD_W-1:0] point_b_x;
        logic signed [COORD_W-1:0] point_b_y;
    } points_t;

    // Data that rides along the square root pipeline
    typedef struct packed {
        logic                     meet;
        logic        [SQ_W-1:0]   d2;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [NUM_W-1:0]  base_x;
        logic signed [NUM_W-1:0]  base_y;
    } sqrt_pl_t;

endpackage

>>> rtl/core/cci_mul.sv
// ============================================================================
// cci_mul
// Two-stage signed multiplier, 65 x 33 bits, split into two 33 x 33 partial
// products that are registered before the final add.
// ============================================================================
module cci_mul (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [cci_pkg::MA_W-1:0]    a,
    input  logic signed [cci_pkg::MB_W-1:0]    b,
    output logic signed [cci_pkg::MP_W-1:0]    prod
);

    localparam int HW = cci_pkg::MA_W - cci_pkg::ML_W;

    logic signed [HW-1:0]               a_lo;
    logic signed [HW-1:0]               a_hi;
    logic signed [cci_pkg::MPP_W-1:0]   lo_next;
    logic signed [cci_pkg::MPP_W-1:0]   hi_next;
    logic signed [cci_pkg::MPP_W-1:0]   lo_reg;
    logic signed [cci_pkg::MPP_W-1:0]   hi_reg;
    logic signed [cci_pkg::MP_W-1:0]    prod_next;
    logic signed [cci_pkg::MP_W-1:0]    prod_reg;

    assign a_lo      = $signed({1'b0, a[cci_pkg::ML_W-1:0]});
    assign a_hi      = $signed(a[cci_pkg::MA_W-1:cci_pkg::ML_W]);
    assign lo_next   = a_lo * b;
    assign hi_next   = a_hi * b;
    assign prod_next = (cci_pkg::MP_W'(hi_reg) <<< cci_pkg::ML_W) + cci_pkg::MP_W'(lo_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

>>> rtl/core/cci_sqrt.sv
// ============================================================================
// cci_sqrt
// Pipelined integer square root: one result bit per stage, restoring
// digit-by-digit, with a side payload carried alongside.
// ============================================================================
module cci_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [cci_pkg::RAD2_W-1:0]      in_rad,
    input  cci_pkg::sqrt_pl_t               in_pl,
    output logic                            out_valid,
    output logic [cci_pkg::ROOT_W-1:0]      out_root,
    output cci_pkg::sqrt_pl_t               out_pl
);

    localparam int STEPS = cci_pkg::ROOT_W;

    logic                                valid_reg [STEPS];
    logic [cci_pkg::SQRT_REM_W-1:0]      rem_reg   [STEPS];
    logic [cci_pkg::ROOT_W-1:0]          root_reg  [STEPS];
    logic [cci_pkg::RAD2_W-1:0]          rad_reg   [STEPS];
    cci_pkg::sqrt_pl_t                   pl_reg    [STEPS];

    for (genvar s = 0; s < STEPS; s++)
    begin : g_step
        logic                            v_in;
        logic [cci_pkg::SQRT_REM_W-1:0]  rem_in;
        logic [cci_pkg::ROOT_W-1:0]      root_in;
        logic [cci_pkg::RAD2_W-1:0]      rad_in;
        cci_pkg::sqrt_pl_t               pl_in;
        logic [cci_pkg::SQRT_REM_W-1:0]  cur;
        logic [cci_pkg::SQRT_REM_W-1:0]  trial;
        logic                            take;

        if (s == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_rad;
            assign pl_in   = in_pl;
        end
        else
        begin : g_next
            assign v_in    = valid_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rad_in  = rad_reg[s-1];
            assign pl_in   = pl_reg[s-1];
        end

        // bring down the next two bits of the argument
        assign cur   = {rem_in[cci_pkg::SQRT_REM_W-3:0],
                        rad_in[cci_pkg::RAD2_W-1:cci_pkg::RAD2_W-2]};
        assign trial = {root_in, 2'b01};
        assign take  = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= take ? (cur - trial) : cur;
                root_reg[s] <= {root_in[cci_pkg::ROOT_W-2:0], take};
                rad_reg[s]  <= rad_in << 2;
                pl_reg[s]   <= pl_in;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1];
    assign out_pl    = pl_reg[STEPS-1];

endmodule

>>> rtl/core/cci_div.sv
// ============================================================================
// cci_div
// Pipelined rounding divide num / (2*d2), ties away from zero, one quotient
// bit per stage, saturated to a signed 32-bit result.
// ============================================================================
module cci_div (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [cci_pkg::NUM_W-1:0]    num,
    input  logic [cci_pkg::SQ_W-1:0]            d2,
    output logic signed [cci_pkg::QUO_W-1:0]    quo
);

    localparam int QW = cci_pkg::QUO_W;
    localparam int HI_W = cci_pkg::NUM_W - QW;

    // prep: magnitude plus half the divisor
    logic                               neg0_reg;
    logic [cci_pkg::NUM_W-1:0]          mag0_reg;
    logic [cci_pkg::DEN_W-1:0]          den0_reg;
    logic [cci_pkg::NUM_W-1:0]          mag_next;

    // range check
    logic                               neg1_reg;
    logic                               ovf1_reg;
    logic [cci_pkg::DIV_REM_W-1:0]      rem1_reg;
    logic [QW-1:0]                      low1_reg;
    logic [cci_pkg::DEN_W-1:0]          den1_reg;

    // bit steps
    logic                               neg_reg [QW];
    logic                               ovf_reg [QW];
    logic [cci_pkg::DIV_REM_W-1:0]      rem_reg [QW];
    logic [QW-1:0]                      low_reg [QW];
    logic [cci_pkg::DEN_W-1:0]          den_reg [QW];
    logic [QW-1:0]                      q_reg   [QW];

    logic [QW-1:0]                      q_last;
    logic [QW-1:0]                      quo_next;
    logic [QW-1:0]                      quo_reg;

    assign mag_next = num[cci_pkg::NUM_W-1]
                    ? (cci_pkg::NUM_W'(d2) - $unsigned(num))
                    : ($unsigned(num) + cci_pkg::NUM_W'(d2));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg0_reg <= num[cci_pkg::NUM_W-1];
            mag0_reg <= mag_next;
            den0_reg <= {d2, 1'b0};

            neg1_reg <= neg0_reg;
            ovf1_reg <= (mag0_reg[cci_pkg::NUM_W-1:QW] >= HI_W'(den0_reg));
            rem1_reg <= mag0_reg[QW+cci_pkg::DIV_REM_W-1:QW];
            low1_reg <= mag0_reg[QW-1:0];
            den1_reg <= den0_reg;
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_step
        logic                           neg_in;
        logic                           ovf_in;
        logic [cci_pkg::DIV_REM_W-1:0]  rem_in;
        logic [QW-1:0]                  low_in;
        logic [cci_pkg::DEN_W-1:0]      den_in;
        logic [QW-1:0]                  q_in;
        logic [cci_pkg::DIV_REM_W-1:0]  trial;
        logic                           take;

        if (s == 0)
        begin : g_first
            assign neg_in = neg1_reg;
            assign ovf_in = ovf1_reg;
            assign rem_in = rem1_reg;
            assign low_in = low1_reg;
            assign den_in = den1_reg;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign neg_in = neg_reg[s-1];
            assign ovf_in = ovf_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign low_in = low_reg[s-1];
            assign den_in = den_reg[s-1];
            assign q_in   = q_reg[s-1];
        end

        assign trial = {rem_in[cci_pkg::DIV_REM_W-2:0], low_in[QW-1]};
        assign take  = (trial >= cci_pkg::DIV_REM_W'(den_in));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[s] <= neg_in;
                ovf_reg[s] <= ovf_in;
                rem_reg[s] <= take ? (trial - cci_pkg::DIV_REM_W'(den_in)) : trial;
                low_reg[s] <= low_in << 1;
                den_reg[s] <= den_in;
                q_reg[s]   <= {q_in[QW-2:0], take};
            end
        end
    end

    assign q_last = q_reg[QW-1];

    // saturate to the signed range
    always_comb
    begin
        if (!neg_reg[QW-1])
        begin
            if (ovf_reg[QW-1] || q_last[QW-1])
            begin
                quo_next = cci_pkg::QUO_POS_MAX;
            end
            else
            begin
                quo_next = q_last;
            end
        end
        else
        begin
            if (ovf_reg[QW-1] || (q_last[QW-1] && (|q_last[QW-2:0])))
            begin
                quo_next = cci_pkg::QUO_NEG_MIN;
            end
            else
            begin
                quo_next = -q_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = $signed(quo_reg);

endmodule

>>> rtl/core/circle_circle_intersection.sv
// ============================================================================
// circle_circle_intersection
// Intersection points of two circles in signed Q16.16, fully pipelined.
// ============================================================================
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+---------------------------
//  circles   | circles_valid / circles_stall  | cci_pkg::circles_t request
//  points    | points_valid  / points_stall   | cci_pkg::points_t result
//
//  One request enters per cycle while circles_stall is low; each passes
//  through 7 front stages, 64 square root stages, 3 product stages, 35 divide
//  stages and 1 output register. Throughput is set by the bit-per-stage
//  square root and divide pipelines, which never iterate.
//  Reset clears all valid bits and the output valid and skid full flags.
//  A result stalled at the output parks the next one in a skid register;
//  only then is the whole pipeline held and circles_stall raised.
//
module circle_circle_intersection (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                circles_valid,
    output logic                circles_stall,
    input  cci_pkg::circles_t   circles,
    output logic                points_valid,
    input  logic                points_stall,
    output cci_pkg::points_t    points
);

    localparam int DW = cci_pkg::DIFF_W;

    // pipeline advance: hold everything only while the skid is full
    logic en;

    // ---------------------------------------------------------------- s0
    logic                       v0_reg;
    cci_pkg::circles_t          in0_reg;

    // ---------------------------------------------------------------- s1
    logic                       v1_reg;
    logic signed [DW-1:0]       dx1_reg, dy1_reg, sx1_reg, sy1_reg;
    logic [cci_pkg::COORD_W-1:0] sum1_reg;
    logic [cci_pkg::RAD_W-1:0]  dif1_reg, r1_1_reg, r2_1_reg;

    // ---------------------------------------------------------------- s2
    logic signed [2*DW-1:0]     dxx_full, dyy_full;
    logic                       v2_reg;
    logic [cci_pkg::SQ_W-1:0]   dxx2_reg, dyy2_reg, sumsq2_reg, difsq2_reg;
    logic [cci_pkg::RSQ_W-1:0]  r1sq2_reg, r2sq2_reg;
    logic signed [DW-1:0]       dx2_reg, dy2_reg, sx2_reg, sy2_reg;
    logic [cci_pkg::SQ_W-1:0]   sumsq_next, difsq_next;
    logic [cci_pkg::RSQ_W-1:0]  r1sq_next, r2sq_next;

    // ---------------------------------------------------------------- s3
    logic [cci_pkg::SQ_W:0]     d2_full;
    logic                       meet_next;
    logic                       v3_reg, meet3_reg;
    logic [cci_pkg::SQ_W-1:0]   d2_3_reg, hi3_reg, lo3_reg;
    logic signed [cci_pkg::E_W-1:0] e3_reg;
    logic signed [DW-1:0]       dx3_reg, dy3_reg, sx3_reg, sy3_reg;

    // ---------------------------------------------------------------- s4/s5/s6
    localparam int KH = cci_pkg::SQ_W / 2;
    logic [cci_pkg::SQ_W-1:0]   k_ll4_reg, k_lh4_reg, k_hl4_reg, k_hh4_reg;
    logic                       v4_reg, meet4_reg, v5_reg, meet5_reg, v6_reg;
    logic [cci_pkg::SQ_W-1:0]   d2_4_reg, d2_5_reg;
    logic signed [DW-1:0]       dx4_reg, dy4_reg, dx5_reg, dy5_reg;
    logic [cci_pkg::RAD2_W-1:0] k5_reg, k6_reg;
    logic signed [cci_pkg::MP_W-1:0] bx1_prod, bx2_prod, by1_prod, by2_prod;
    cci_pkg::sqrt_pl_t          pl6_reg;

    // ---------------------------------------------------------------- root
    logic                       sq_valid;
    logic [cci_pkg::ROOT_W-1:0] sq_root;
    cci_pkg::sqrt_pl_t          sq_pl;
    logic                       t1_v_reg, t2_v_reg;
    cci_pkg::sqrt_pl_t          t1_pl_reg, t2_pl_reg;
    logic signed [cci_pkg::MP_W-1:0] sdx_prod, sdy_prod;

    // ---------------------------------------------------------------- numerators
    logic                       vn_reg, meetn_reg;
    logic [cci_pkg::SQ_W-1:0]   d2n_reg;
    logic signed [cci_pkg::NUM_W-1:0] n_ax_reg, n_ay_reg, n_bx_reg, n_by_reg;

    // ---------------------------------------------------------------- divide
    logic                       chain_v_reg    [cci_pkg::DIV_LAT];
    logic                       chain_meet_reg [cci_pkg::DIV_LAT];
    logic signed [cci_pkg::QUO_W-1:0] q_ax, q_ay, q_bx, q_by;

    // ---------------------------------------------------------------- output
    logic                       pipe_valid;
    cci_pkg::points_t           pipe_data;
    logic                       out_valid_reg, out_valid_next;
    logic                       skid_full_reg, skid_full_next;
    cci_pkg::points_t           out_reg, out_next, skid_reg, skid_next;

    assign en            = !skid_full_reg;
    assign circles_stall = skid_full_reg;

    // ================================================================ valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            t1_v_reg <= 1'b0;
            t2_v_reg <= 1'b0;
            vn_reg   <= 1'b0;
            for (int i = 0; i < cci_pkg::DIV_LAT; i++)
            begin
                chain_v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v0_reg   <= circles_valid;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            t1_v_reg <= sq_valid;
            t2_v_reg <= t1_v_reg;
            vn_reg   <= t2_v_reg;
            chain_v_reg[0] <= vn_reg;
            for (int i = 1; i < cci_pkg::DIV_LAT; i++)
            begin
                chain_v_reg[i] <= chain_v_reg[i-1];
            end
        end
    end

    // ================================================================ front end
    assign dxx_full   = dx1_reg * dx1_reg;
    assign dyy_full   = dy1_reg * dy1_reg;
    assign sumsq_next = sum1_reg * sum1_reg;
    assign difsq_next = dif1_reg * dif1_reg;
    assign r1sq_next  = r1_1_reg * r1_1_reg;
    assign r2sq_next  = r2_1_reg * r2_1_reg;

    // circles meet when (r1-r2)^2 <= D2 <= (r1+r2)^2; drop coincident centres
    assign d2_full   = {1'b0, dxx2_reg} + {1'b0, dyy2_reg};
    assign meet_next = (d2_full != '0)
                    && ({1'b0, difsq2_reg} <= d2_full)
                    && (d2_full <= {1'b0, sumsq2_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in0_reg  <= circles;

            dx1_reg  <= DW'(in0_reg.second_center_x) - DW'(in0_reg.first_center_x);
            dy1_reg  <= DW'(in0_reg.second_center_y) - DW'(in0_reg.first_center_y);
            sx1_reg  <= DW'(in0_reg.second_center_x) + DW'(in0_reg.first_center_x);
            sy1_reg  <= DW'(in0_reg.second_center_y) + DW'(in0_reg.first_center_y);
            sum1_reg <= cci_pkg::COORD_W'(in0_reg.first_radius)
                      + cci_pkg::COORD_W'(in0_reg.second_radius);
            dif1_reg <= (in0_reg.first_radius >= in0_reg.second_radius)
                      ? (in0_reg.first_radius - in0_reg.second_radius)
                      : (in0_reg.second_radius - in0_reg.first_radius);
            r1_1_reg <= in0_reg.first_radius;
            r2_1_reg <= in0_reg.second_radius;

            dxx2_reg   <= dxx_full[cci_pkg::SQ_W-1:0];
            dyy2_reg   <= dyy_full[cci_pkg::SQ_W-1:0];
            sumsq2_reg <= sumsq_next;
            difsq2_reg <= difsq_next;
            r1sq2_reg  <= r1sq_next;
            r2sq2_reg  <= r2sq_next;
            dx2_reg    <= dx1_reg;
            dy2_reg    <= dy1_reg;
            sx2_reg    <= sx1_reg;
            sy2_reg    <= sy1_reg;

            // zero the root factors when there is no meeting point
            meet3_reg <= meet_next;
            d2_3_reg  <= d2_full[cci_pkg::SQ_W-1:0];
            hi3_reg   <= meet_next ? (sumsq2_reg - d2_full[cci_pkg::SQ_W-1:0]) : '0;
            lo3_reg   <= meet_next ? (d2_full[cci_pkg::SQ_W-1:0] - difsq2_reg) : '0;
            e3_reg    <= $signed({1'b0, r1sq2_reg}) - $signed({1'b0, r2sq2_reg});
            dx3_reg   <= dx2_reg;
            dy3_reg   <= dy2_reg;
            sx3_reg   <= sx2_reg;
            sy3_reg   <= sy2_reg;

            // root argument K = hi * lo as four partial products
            k_ll4_reg <= hi3_reg[KH-1:0]            * lo3_reg[KH-1:0];
            k_lh4_reg <= hi3_reg[KH-1:0]            * lo3_reg[cci_pkg::SQ_W-1:KH];
            k_hl4_reg <= hi3_reg[cci_pkg::SQ_W-1:KH] * lo3_reg[KH-1:0];
            k_hh4_reg <= hi3_reg[cci_pkg::SQ_W-1:KH] * lo3_reg[cci_pkg::SQ_W-1:KH];
            meet4_reg <= meet3_reg;
            d2_4_reg  <= d2_3_reg;
            dx4_reg   <= dx3_reg;
            dy4_reg   <= dy3_reg;

            k5_reg    <= {k_hh4_reg, k_ll4_reg}
                       + {{KH{1'b0}}, k_lh4_reg, {KH{1'b0}}}
                       + {{KH{1'b0}}, k_hl4_reg, {KH{1'b0}}};
            meet5_reg <= meet4_reg;
            d2_5_reg  <= d2_4_reg;
            dx5_reg   <= dx4_reg;
            dy5_reg   <= dy4_reg;

            // base terms (x1+x2)*D2 + E*dx and (y1+y2)*D2 + E*dy
            k6_reg         <= k5_reg;
            pl6_reg.meet   <= meet5_reg;
            pl6_reg.d2     <= d2_5_reg;
            pl6_reg.dx     <= dx5_reg;
            pl6_reg.dy     <= dy5_reg;
            pl6_reg.base_x <= cci_pkg::NUM_W'(bx1_prod) + cci_pkg::NUM_W'(bx2_prod);
            pl6_reg.base_y <= cci_pkg::NUM_W'(by1_prod) + cci_pkg::NUM_W'(by2_prod);
        end
    end

    cci_mul u_mul_bx1 (
        .clk  (clk),
        .en   (en),
        .a    ($signed({1'b0, d2_3_reg})),
        .b    (sx3_reg),
        .prod (bx1_prod)
    );

    cci_mul u_mul_bx2 (
        .clk  (clk),
        .en   (en),
        .a    (cci_pkg::MA_W'(e3_reg)),
        .b    (dx3_reg),
        .prod (bx2_prod)
    );

    cci_mul u_mul_by1 (
        .clk  (clk),
        .en   (en),
        .a    ($signed({1'b0, d2_3_reg})),
        .b    (sy3_reg),
        .prod (by1_prod)
    );

    cci_mul u_mul_by2 (
        .clk  (clk),
        .en   (en),
        .a    (cci_pkg::MA_W'(e3_reg)),
        .b    (dy3_reg),
        .prod (by2_prod)
    );

    // ================================================================ root
    cci_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .in_rad    (k6_reg),
        .in_pl     (pl6_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_pl    (sq_pl)
    );

    cci_mul u_mul_sdy (
        .clk  (clk),
        .en   (en),
        .a    ($signed({1'b0, sq_root})),
        .b    (sq_pl.dy),
        .prod (sdy_prod)
    );

    cci_mul u_mul_sdx (
        .clk  (clk),
        .en   (en),
        .a    ($signed({1'b0, sq_root})),
        .b    (sq_pl.dx),
        .prod (sdx_prod)
    );

    // ================================================================ numerators
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_pl_reg <= sq_pl;
            t2_pl_reg <= t1_pl_reg;

            meetn_reg <= t2_pl_reg.meet;
            d2n_reg   <= t2_pl_reg.d2;
            n_ax_reg  <= t2_pl_reg.base_x + cci_pkg::NUM_W'(sdy_prod);
            n_ay_reg  <= t2_pl_reg.base_y - cci_pkg::NUM_W'(sdx_prod);
            n_bx_reg  <= t2_pl_reg.base_x - cci_pkg::NUM_W'(sdy_prod);
            n_by_reg  <= t2_pl_reg.base_y + cci_pkg::NUM_W'(sdx_prod);

            chain_meet_reg[0] <= meetn_reg;
            for (int i = 1; i < cci_pkg::DIV_LAT; i++)
            begin
                chain_meet_reg[i] <= chain_meet_reg[i-1];
            end
        end
    end

    // ================================================================ divide
    cci_div u_div_ax (.clk(clk), .en(en), .num(n_ax_reg), .d2(d2n_reg), .quo(q_ax));
    cci_div u_div_ay (.clk(clk), .en(en), .num(n_ay_reg), .d2(d2n_reg), .quo(q_ay));
    cci_div u_div_bx (.clk(clk), .en(en), .num(n_bx_reg), .d2(d2n_reg), .quo(q_bx));
    cci_div u_div_by (.clk(clk), .en(en), .num(n_by_reg), .d2(d2n_reg), .quo(q_by));

    // drop the points when the circles do not meet
    always_comb
    begin
        pipe_valid           = chain_v_reg[cci_pkg::DIV_LAT-1];
        pipe_data.meet_valid = chain_meet_reg[cci_pkg::DIV_LAT-1];
        pipe_data.point_a_x  = pipe_data.meet_valid ? q_ax : '0;
        pipe_data.point_a_y  = pipe_data.meet_valid ? q_ay : '0;
        pipe_data.point_b_x  = pipe_data.meet_valid ? q_bx : '0;
        pipe_data.point_b_y  = pipe_data.meet_valid ? q_by : '0;
    end

    // ================================================================ output
    // output register with a one-entry skid; a stalled result holds, the
    // next one parks in the skid, and the pipeline halts only when it is full
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        skid_full_next = skid_full_reg;
        skid_next      = skid_reg;
        if (out_valid_reg && points_stall)
        begin
            if (pipe_valid && !skid_full_reg)
            begin
                skid_next      = pipe_data;
                skid_full_next = 1'b1;
            end
        end
        else if (skid_full_reg)
        begin
            out_next       = skid_reg;
            out_valid_next = 1'b1;
            skid_full_next = 1'b0;
        end
        else
        begin
            out_next       = pipe_data;
            out_valid_next = pipe_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign points_valid = out_valid_reg;
    assign points       = out_reg;

endmodule
